@@ sv/c2s_pkg.sv @@
// Package for the Cartesian to spherical converter: shared widths, turn constants and
// the CORDIC arctangent table.
// No dependencies; the interface, CORDIC, top-level and testbench files refer to it by scoped names.
package c2s_pkg;

   // Default parameter values of the top level.
   localparam int COORD_WIDTH_DEF   = 32;
   localparam int CORDIC_STAGES_DEF = 32;

   // Fixed-point scale of the coordinates and the radius.
   localparam int FRAC_BITS = 16;

   // Angles are unsigned binary fractions of a turn.
   localparam int ANGLE_W = 32;
   typedef logic [ANGLE_W-1:0] angle_type;

   localparam angle_type QUARTER_TURN = 32'h4000_0000;
   localparam angle_type HALF_TURN    = 32'h8000_0000;

   // The normalizer works on a 64-bit word. It moves the leading one to the top
   // bit in six conditional shifts, and a final right shift leaves it at bit 59.
   localparam int NORM_W     = 64;
   localparam int NORM_STEPS = 6;
   localparam int NORM_SHIFT = 4;

   // CORDIC vector and angle accumulator widths.
   localparam int CORDIC_W = 64;
   localparam int ACC_W    = 34;

   // Arctangent table length and index width.
   localparam int ATAN_LEN   = 48;
   localparam int ATAN_IDX_W = 6;

   // Returns round(atan(2^-idx) / (2 pi) * 2^32).
   function automatic angle_type atan_entry(input logic [ATAN_IDX_W-1:0] idx);
      angle_type val;
      case (idx)
         6'd0:    val = 32'd536870912;
         6'd1:    val = 32'd316933406;
         6'd2:    val = 32'd167458907;
         6'd3:    val = 32'd85004756;
         6'd4:    val = 32'd42667331;
         6'd5:    val = 32'd21354465;
         6'd6:    val = 32'd10679838;
         6'd7:    val = 32'd5340245;
         6'd8:    val = 32'd2670163;
         6'd9:    val = 32'd1335087;
         6'd10:   val = 32'd667544;
         6'd11:   val = 32'd333772;
         6'd12:   val = 32'd166886;
         6'd13:   val = 32'd83443;
         6'd14:   val = 32'd41722;
         6'd15:   val = 32'd20861;
         6'd16:   val = 32'd10430;
         6'd17:   val = 32'd5215;
         6'd18:   val = 32'd2608;
         6'd19:   val = 32'd1304;
         6'd20:   val = 32'd652;
         6'd21:   val = 32'd326;
         6'd22:   val = 32'd163;
         6'd23:   val = 32'd81;
         6'd24:   val = 32'd41;
         6'd25:   val = 32'd20;
         6'd26:   val = 32'd10;
         6'd27:   val = 32'd5;
         6'd28:   val = 32'd3;
         6'd29:   val = 32'd1;
         6'd30:   val = 32'd1;
         default: val = 32'd0;
      endcase
      return val;
   endfunction

endpackage

@@ sv/c2s_if.sv @@
// Valid/ready channel interfaces for the point and result beats.
// Depends on c2s_pkg for the default coordinate width and the angle type.
interface c2s_req_if #(
   parameter int COORD_WIDTH = c2s_pkg::COORD_WIDTH_DEF
);
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] x_coord;
   logic signed [COORD_WIDTH-1:0] y_coord;
   logic signed [COORD_WIDTH-1:0] z_coord;

   modport source (output valid, output x_coord, output y_coord, output z_coord,
                   input ready);
   modport sink   (input valid, input x_coord, input y_coord, input z_coord,
                   output ready);
endinterface

interface c2s_rsp_if #(
   parameter int COORD_WIDTH = c2s_pkg::COORD_WIDTH_DEF
);
   logic                   valid;
   logic                   ready;
   logic [COORD_WIDTH-1:0] radius;
   c2s_pkg::angle_type     polar_angle;
   c2s_pkg::angle_type     azimuth;

   modport source (output valid, output radius, output polar_angle, output azimuth,
                   input ready);
   modport sink   (input valid, input radius, input polar_angle, input azimuth,
                   output ready);
endinterface

@@ sv/c2s_isqrt.sv @@
// Pipelined integer square root: one result bit per register stage, restoring method.
// Depends on nothing but the stage enable from the top level.
module c2s_isqrt #(
   parameter int RES_W = 48
) (
   input  logic                 clock,
   input  logic                 advance,
   input  logic [2*RES_W-1:0]   radicand,
   output logic [RES_W-1:0]     root
);

   localparam int RW = 2 * RES_W;

   // Remainder and partial root after each stage. The last remainder is not kept.
   logic [RW-1:0]    rem_ff  [RES_W-1];
   logic [RES_W-1:0] root_ff [RES_W];

   for (genvar k = 0; k < RES_W; k++) begin : g_stage
      localparam int B = RES_W - 1 - k;
      logic [RW-1:0]    src_rem;
      logic [RES_W-1:0] src_root;
      logic [RW-1:0]    trial;
      logic             take;

      if (k == 0) begin : g_first
         assign src_rem  = radicand;
         assign src_root = '0;
      end else begin : g_next
         assign src_rem  = rem_ff[k-1];
         assign src_root = root_ff[k-1];
      end

      // (r + 2^b)^2 - r^2 = r * 2^(b+1) + 2^(2b); r has no bits at or below b.
      assign trial = (RW'(src_root) << (B + 1)) | (RW'(1) << (2 * B));
      assign take  = (src_rem >= trial);

      always_ff @(posedge clock) begin
         if (advance) begin
            root_ff[k] <= take ? (src_root | (RES_W'(1) << B)) : src_root;
         end
      end

      if (k < RES_W - 1) begin : g_rem
         always_ff @(posedge clock) begin
            if (advance) begin
               rem_ff[k] <= take ? (src_rem - trial) : src_rem;
            end
         end
      end
   end

   assign root = root_ff[RES_W-1];

endmodule

@@ sv/c2s_cordic.sv @@
// First-quadrant atan2 of two magnitudes: pipelined normalizer, CORDIC vectoring
// iterations one per stage, then a clamp. Depends on c2s_pkg for widths and the table.
module c2s_cordic #(
   parameter int IN_W   = 48,
   parameter int STAGES = c2s_pkg::CORDIC_STAGES_DEF
) (
   input  logic                clock,
   input  logic                advance,
   input  logic [IN_W-1:0]     mag_x,
   input  logic [IN_W-1:0]     mag_y,
   output c2s_pkg::angle_type  angle
);

   localparam int NW    = c2s_pkg::NORM_W;
   localparam int NS    = c2s_pkg::NORM_STEPS;
   localparam int CW    = c2s_pkg::CORDIC_W;
   localparam int AW    = c2s_pkg::ACC_W;
   localparam int IW    = c2s_pkg::ATAN_IDX_W;
   localparam int ITERS = (STAGES < c2s_pkg::ATAN_LEN) ? STAGES : c2s_pkg::ATAN_LEN;
   localparam logic signed [AW-1:0] QUARTER_S = AW'(c2s_pkg::QUARTER_TURN);

   logic [NW-1:0]          na_ff  [NS];
   logic [NW-1:0]          nb_ff  [NS];
   logic signed [CW-1:0]   vx_ff  [ITERS-1];
   logic signed [CW-1:0]   vy_ff  [ITERS-1];
   logic signed [AW-1:0]   acc_ff [ITERS];
   c2s_pkg::angle_type     angle_ff;

   // Normalizer: shift both magnitudes left while the top part of their OR is zero.
   for (genvar j = 0; j < NS; j++) begin : g_norm
      localparam int SH = 1 << (NS - 1 - j);
      logic [NW-1:0] src_a;
      logic [NW-1:0] src_b;
      logic [NW-1:0] src_m;

      if (j == 0) begin : g_first
         assign src_a = NW'(mag_x);
         assign src_b = NW'(mag_y);
      end else begin : g_next
         assign src_a = na_ff[j-1];
         assign src_b = nb_ff[j-1];
      end
      assign src_m = src_a | src_b;

      always_ff @(posedge clock) begin
         if (advance) begin
            if (src_m[NW-1 -: SH] == '0) begin
               na_ff[j] <= src_a << SH;
               nb_ff[j] <= src_b << SH;
            end else begin
               na_ff[j] <= src_a;
               nb_ff[j] <= src_b;
            end
         end
      end
   end

   // Vectoring iterations: drive y toward zero and accumulate the rotation.
   for (genvar i = 0; i < ITERS; i++) begin : g_iter
      logic signed [CW-1:0] src_x;
      logic signed [CW-1:0] src_y;
      logic signed [CW-1:0] dx;
      logic signed [CW-1:0] dy;
      logic signed [AW-1:0] src_acc;
      logic signed [AW-1:0] step;

      if (i == 0) begin : g_first
         assign src_x   = $signed({{c2s_pkg::NORM_SHIFT{1'b0}},
                                   na_ff[NS-1][NW-1:c2s_pkg::NORM_SHIFT]});
         assign src_y   = $signed({{c2s_pkg::NORM_SHIFT{1'b0}},
                                   nb_ff[NS-1][NW-1:c2s_pkg::NORM_SHIFT]});
         assign src_acc = '0;
      end else begin : g_next
         assign src_x   = vx_ff[i-1];
         assign src_y   = vy_ff[i-1];
         assign src_acc = acc_ff[i-1];
      end

      assign dx   = src_y >>> i;
      assign dy   = src_x >>> i;
      assign step = $signed(AW'(c2s_pkg::atan_entry(IW'(i))));

      always_ff @(posedge clock) begin
         if (advance) begin
            if (src_y > 0) begin
               acc_ff[i] <= src_acc + step;
            end else if (src_y < 0) begin
               acc_ff[i] <= src_acc - step;
            end else begin
               acc_ff[i] <= src_acc;
            end
         end
      end

      if (i < ITERS - 1) begin : g_vec
         always_ff @(posedge clock) begin
            if (advance) begin
               if (src_y > 0) begin
                  vx_ff[i] <= src_x + dx;
                  vy_ff[i] <= src_y - dy;
               end else if (src_y < 0) begin
                  vx_ff[i] <= src_x - dx;
                  vy_ff[i] <= src_y + dy;
               end else begin
                  vx_ff[i] <= src_x;
                  vy_ff[i] <= src_y;
               end
            end
         end
      end
   end

   // Clamp the accumulated angle to the first quadrant.
   always_ff @(posedge clock) begin
      if (advance) begin
         if (acc_ff[ITERS-1] < 0) begin
            angle_ff <= '0;
         end else if (acc_ff[ITERS-1] > QUARTER_S) begin
            angle_ff <= c2s_pkg::QUARTER_TURN;
         end else begin
            angle_ff <= acc_ff[ITERS-1][c2s_pkg::ANGLE_W-1:0];
         end
      end
   end

   assign angle = angle_ff;

endmodule

@@ sv/cartesian_to_spherical_top.sv @@
// Cartesian to spherical converter, fully pipelined. It takes one point beat per cycle
// while the result register is not held, and returns one result beat per point, in
// order. The depth is set by the planar-radius square root, which resolves one bit per
// stage over COORD_WIDTH + 16 stages, followed by the polar-angle CORDIC (six
// normalizing stages, one stage per iteration and a clamp). The radius root and the
// azimuth CORDIC run alongside and are delayed to match. When the result register is
// held, every stage holds with it.
// Depends on c2s_pkg, c2s_if, c2s_isqrt and c2s_cordic.
module cartesian_to_spherical_top #(
   parameter int COORD_WIDTH   = c2s_pkg::COORD_WIDTH_DEF,
   parameter int CORDIC_STAGES = c2s_pkg::CORDIC_STAGES_DEF
) (
   input  logic         clock,
   input  logic         reset,
   c2s_req_if.sink      req_bus,
   c2s_rsp_if.source    rsp_bus
);

   localparam int W      = COORD_WIDTH;
   localparam int FB     = c2s_pkg::FRAC_BITS;
   localparam int RHO_W  = W + FB;
   localparam int ITERS  = (CORDIC_STAGES < c2s_pkg::ATAN_LEN) ?
                           CORDIC_STAGES : c2s_pkg::ATAN_LEN;
   localparam int L_C    = c2s_pkg::NORM_STEPS + ITERS + 1;
   // Pipeline depths counted in registers after the input beat is taken.
   localparam int D_RHO  = 3 + RHO_W;
   localparam int D_P    = D_RHO + L_C;
   localparam int AZ_DLY = D_RHO - 1;
   localparam int AZM_DLY = D_P - 1 - L_C;
   localparam int RAD_DLY = D_P - 3 - W;

   logic advance;

   // Stage 1: magnitudes and signs.
   logic [W-1:0] x_u;
   logic [W-1:0] y_u;
   logic [W-1:0] z_u;
   logic [W-1:0] ax_in;
   logic [W-1:0] ay_in;
   logic [W-1:0] az_in;
   logic [W-1:0] ax_ff;
   logic [W-1:0] ay_ff;
   logic [W-1:0] az_ff;

   // Stages 2 and 3: squares, then the planar and full sums.
   logic [2*W-1:0] sq_x_ff;
   logic [2*W-1:0] sq_y_ff;
   logic [2*W-1:0] sq_z_ff;
   logic [2*W-1:0] plane_ff;
   logic [2*W-1:0] full_ff;

   // Valid bits and sign bits travel with the data through every stage.
   logic [D_P-1:0] valid_ff;
   logic [2:0]     sign_ff [D_P];

   // Alignment lines.
   logic [W-1:0]       az_line_ff  [AZ_DLY];
   c2s_pkg::angle_type azm_line_ff [AZM_DLY];
   logic [W-1:0]       rad_line_ff [RAD_DLY];

   logic [RHO_W-1:0]   rho;
   logic [W-1:0]       radius_raw;
   c2s_pkg::angle_type polar_q;
   c2s_pkg::angle_type azim_q;

   // Result register.
   logic               rsp_valid_ff;
   logic [W-1:0]       radius_ff;
   c2s_pkg::angle_type polar_ff;
   c2s_pkg::angle_type azim_ff;
   c2s_pkg::angle_type polar_in;
   c2s_pkg::angle_type azim_in;
   logic               nx_d;
   logic               ny_d;
   logic               nz_d;

   // The whole pipeline moves whenever the result register is free or being taken.
   // No point beat is taken while reset is held.
   assign advance       = !rsp_valid_ff || rsp_bus.ready;
   assign req_bus.ready = advance && !reset;

   // Two's complement magnitudes; the most negative value maps to 2^(W-1) exactly.
   assign x_u   = req_bus.x_coord;
   assign y_u   = req_bus.y_coord;
   assign z_u   = req_bus.z_coord;
   assign ax_in = x_u[W-1] ? (~x_u + W'(1)) : x_u;
   assign ay_in = y_u[W-1] ? (~y_u + W'(1)) : y_u;
   assign az_in = z_u[W-1] ? (~z_u + W'(1)) : z_u;

   // Front of the datapath: magnitudes, squares and sums.
   always_ff @(posedge clock) begin
      if (advance) begin
         ax_ff    <= ax_in;
         ay_ff    <= ay_in;
         az_ff    <= az_in;
         sq_x_ff  <= (2*W)'(ax_ff) * (2*W)'(ax_ff);
         sq_y_ff  <= (2*W)'(ay_ff) * (2*W)'(ay_ff);
         sq_z_ff  <= (2*W)'(az_ff) * (2*W)'(az_ff);
         plane_ff <= sq_x_ff + sq_y_ff;
         full_ff  <= sq_x_ff + sq_y_ff + sq_z_ff;
      end
   end

   // Valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= {valid_ff[D_P-2:0], req_bus.valid};
      end
   end

   // Sign bits of x, y and z, delayed to the output stage.
   always_ff @(posedge clock) begin
      if (advance) begin
         sign_ff[0] <= {x_u[W-1], y_u[W-1], z_u[W-1]};
         for (int k = 1; k < D_P; k++) begin
            sign_ff[k] <= sign_ff[k-1];
         end
      end
   end

   // Planar radius in Q32 and the radius itself.
   c2s_isqrt #(
      .RES_W    (RHO_W)
   ) u_rho_sqrt (
      .clock    (clock),
      .advance  (advance),
      .radicand ({plane_ff, {(2*FB){1'b0}}}),
      .root     (rho)
   );

   c2s_isqrt #(
      .RES_W    (W)
   ) u_radius_sqrt (
      .clock    (clock),
      .advance  (advance),
      .radicand (full_ff),
      .root     (radius_raw)
   );

   // |z| waits for the planar radius.
   always_ff @(posedge clock) begin
      if (advance) begin
         az_line_ff[0] <= az_ff;
         for (int k = 1; k < AZ_DLY; k++) begin
            az_line_ff[k] <= az_line_ff[k-1];
         end
      end
   end

   // Polar angle: atan2(planar radius, |z|) with both in Q32.
   c2s_cordic #(
      .IN_W    (RHO_W),
      .STAGES  (CORDIC_STAGES)
   ) u_polar_cordic (
      .clock   (clock),
      .advance (advance),
      .mag_x   ({az_line_ff[AZ_DLY-1], {FB{1'b0}}}),
      .mag_y   (rho),
      .angle   (polar_q)
   );

   // Azimuth: atan2(|y|, |x|), started early and delayed to meet the polar angle.
   c2s_cordic #(
      .IN_W    (W),
      .STAGES  (CORDIC_STAGES)
   ) u_azim_cordic (
      .clock   (clock),
      .advance (advance),
      .mag_x   (ax_ff),
      .mag_y   (ay_ff),
      .angle   (azim_q)
   );

   always_ff @(posedge clock) begin
      if (advance) begin
         azm_line_ff[0] <= azim_q;
         for (int k = 1; k < AZM_DLY; k++) begin
            azm_line_ff[k] <= azm_line_ff[k-1];
         end
         rad_line_ff[0] <= radius_raw;
         for (int k = 1; k < RAD_DLY; k++) begin
            rad_line_ff[k] <= rad_line_ff[k-1];
         end
      end
   end

   // Map the first-quadrant angles to their quadrants.
   always_comb begin
      nx_d = sign_ff[D_P-1][2];
      ny_d = sign_ff[D_P-1][1];
      nz_d = sign_ff[D_P-1][0];
      polar_in = nz_d ? (c2s_pkg::HALF_TURN - polar_q) : polar_q;
      if (!nx_d && !ny_d) begin
         azim_in = azm_line_ff[AZM_DLY-1];
      end else if (nx_d && !ny_d) begin
         azim_in = c2s_pkg::HALF_TURN - azm_line_ff[AZM_DLY-1];
      end else if (nx_d && ny_d) begin
         azim_in = c2s_pkg::HALF_TURN + azm_line_ff[AZM_DLY-1];
      end else begin
         azim_in = '0 - azm_line_ff[AZM_DLY-1];
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= valid_ff[D_P-1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         radius_ff <= rad_line_ff[RAD_DLY-1];
         polar_ff  <= polar_in;
         azim_ff   <= azim_in;
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.radius      = radius_ff;
   assign rsp_bus.polar_angle = polar_ff;
   assign rsp_bus.azimuth     = azim_ff;

endmodule

@@ tb/cartesian_to_spherical_top_tb.sv @@
// Self-checking testbench for cartesian_to_spherical_top: directed and random point beats,
// each result beat checked in order against a table value or a bit-exact predictor.
// Depends on c2s_pkg, c2s_if and the RTL of cartesian_to_spherical_top.
module cartesian_to_spherical_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CW          = c2s_pkg::COORD_WIDTH_DEF;
   localparam int STAGES      = c2s_pkg::CORDIC_STAGES_DEF;
   localparam int ARC_LEN     = 48;
   localparam int NORM_BIT    = 59;
   localparam int RANDOM_PTS  = 1550;
   localparam int STALL_LIMIT = 2000;
   localparam int DRAIN_WAIT  = 100;

   localparam logic [CW-1:0] COORD_MAX = {1'b0, {(CW-1){1'b1}}};
   localparam logic [CW-1:0] COORD_MIN = {1'b1, {(CW-1){1'b0}}};
   localparam logic [CW-1:0] ONE_UNIT  = 1 << c2s_pkg::FRAC_BITS;

   typedef struct packed {
      logic signed [CW-1:0] x;
      logic signed [CW-1:0] y;
      logic signed [CW-1:0] z;
   } point_t;

   typedef struct packed {
      logic [CW-1:0]      radius;
      c2s_pkg::angle_type polar;
      c2s_pkg::angle_type azimuth;
   } sph_result_t;

   typedef struct packed {
      point_t      pt;
      logic        known;
      sph_result_t want;
   } stim_row_t;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic        point_valid  = 1'b0;
   point_t      point_beat   = '0;
   logic        result_ready = 1'b0;
   logic        steady       = 1'b0;
   int          mismatch_count = 0;
   int          quiet_cycles   = 0;
   sph_result_t pending_results[$];
   stim_row_t   directed_rows[$];

   c2s_req_if #(.COORD_WIDTH(CW)) req_bus();
   c2s_rsp_if #(.COORD_WIDTH(CW)) rsp_bus();

   assign req_bus.valid   = point_valid;
   assign req_bus.x_coord = point_beat.x;
   assign req_bus.y_coord = point_beat.y;
   assign req_bus.z_coord = point_beat.z;
   assign rsp_bus.ready   = result_ready;

   cartesian_to_spherical_top #(
      .COORD_WIDTH   (CW),
      .CORDIC_STAGES (STAGES)
   ) u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Arctangent of 2^-i as a fraction of a turn, scaled by 2^32 and rounded.
   function automatic longint arc_step(input int i);
      case (i)
         0: return 536870912;   1: return 316933406;   2: return 167458907;
         3: return 85004756;    4: return 42667331;    5: return 21354465;
         6: return 10679838;    7: return 5340245;     8: return 2670163;
         9: return 1335087;     10: return 667544;     11: return 333772;
         12: return 166886;     13: return 83443;      14: return 41722;
         15: return 20861;      16: return 10430;      17: return 5215;
         18: return 2608;       19: return 1304;       20: return 652;
         21: return 326;        22: return 163;        23: return 81;
         24: return 41;         25: return 20;         26: return 10;
         27: return 5;          28: return 3;          29: return 1;
         30: return 1;
         default: return 0;
      endcase
   endfunction

   // Floor of the exact square root of a 128-bit value, one bit at a time.
   function automatic logic [63:0] root_floor(input logic [127:0] n);
      logic [63:0]  r;
      logic [63:0]  t;
      logic [127:0] sq;
      r = '0;
      for (int b = 63; b >= 0; b--) begin
         t  = r | (64'd1 << b);
         sq = {64'd0, t} * {64'd0, t};
         if (sq <= n) r = t;
      end
      return r;
   endfunction

   // First-quadrant angle of (adj, opp) by vectoring CORDIC on normalized magnitudes.
   function automatic c2s_pkg::angle_type turn_angle(input logic [63:0] adj,
                                                     input logic [63:0] opp);
      logic [63:0] m;
      int          top;
      longint      vx, vy, dx, dy, acc;
      m = adj | opp;
      if (m == 0) return '0;
      top = 63;
      while (!m[top]) top--;
      if (top > NORM_BIT) begin
         adj = adj >> (top - NORM_BIT);
         opp = opp >> (top - NORM_BIT);
      end else begin
         adj = adj << (NORM_BIT - top);
         opp = opp << (NORM_BIT - top);
      end
      vx  = longint'(adj);
      vy  = longint'(opp);
      acc = 0;
      for (int i = 0; i < STAGES && i < ARC_LEN; i++) begin
         dx = vy >>> i;
         dy = vx >>> i;
         if (vy > 0) begin
            vx  = vx + dx;
            vy  = vy - dy;
            acc = acc + arc_step(i);
         end else if (vy < 0) begin
            vx  = vx - dx;
            vy  = vy + dy;
            acc = acc - arc_step(i);
         end
      end
      if (acc < 0) acc = 0;
      if (acc > longint'(c2s_pkg::QUARTER_TURN)) acc = longint'(c2s_pkg::QUARTER_TURN);
      return acc[31:0];
   endfunction

   // Magnitude of a two's complement coordinate; the most negative value is exact.
   function automatic logic [63:0] coord_mag(input logic [CW-1:0] v);
      return v[CW-1] ? ((64'd1 << CW) - 64'(v)) : 64'(v);
   endfunction

   // Spherical coordinates of one point.
   function automatic sph_result_t spherical_of(input point_t pt);
      logic [63:0]        ax, ay, az, rho;
      logic [127:0]       plane, full;
      logic               nx, ny, nz;
      c2s_pkg::angle_type a;
      sph_result_t        res;
      nx = pt.x[CW-1];
      ny = pt.y[CW-1];
      nz = pt.z[CW-1];
      ax = coord_mag(pt.x);
      ay = coord_mag(pt.y);
      az = coord_mag(pt.z);
      plane = 128'(ax) * 128'(ax) + 128'(ay) * 128'(ay);
      full  = plane + 128'(az) * 128'(az);

      // Planar radius is kept in Q32 and paired with |z| lifted to the same scale.
      rho = root_floor(plane << 32);
      a   = turn_angle(az << 16, rho);
      res.polar = nz ? c2s_pkg::HALF_TURN - a : a;
      if (az == 0 && rho == 0) res.polar = '0;

      // Azimuth: first-quadrant angle mapped by the signs of x and y.
      a = turn_angle(ax, ay);
      case ({nx, ny})
         2'b00:   res.azimuth = a;
         2'b10:   res.azimuth = c2s_pkg::HALF_TURN - a;
         2'b11:   res.azimuth = c2s_pkg::HALF_TURN + a;
         default: res.azimuth = 32'd0 - a;
      endcase
      if (ax == 0 && ay == 0) res.azimuth = '0;

      res.radius = CW'(root_floor(full));
      return res;
   endfunction

   // One random coordinate, spread over full range, small values, zero and extremes.
   function automatic logic [CW-1:0] random_coord();
      case ($urandom_range(9))
         5, 6:    return $signed($urandom()) >>> $urandom_range(31, 10);
         7:       return '0;
         8: begin
            case ($urandom_range(4))
               0:       return COORD_MAX;
               1:       return COORD_MIN;
               2:       return 1;
               3:       return '1;
               default: return '0;
            endcase
         end
         9:       return $urandom() & (32'hFFFF_FFFF >> $urandom_range(31));
         default: return $urandom();
      endcase
   endfunction

   task automatic add_row(input logic [CW-1:0] x, input logic [CW-1:0] y,
                          input logic [CW-1:0] z, input logic known,
                          input logic [CW-1:0] r, input c2s_pkg::angle_type p,
                          input c2s_pkg::angle_type az);
      stim_row_t row;
      row.pt      = '{x, y, z};
      row.known   = known;
      row.want    = '{r, p, az};
      directed_rows.push_back(row);
   endtask

   // Drive one point beat, with an occasional idle cycle before it, and hold it until taken.
   task automatic send_point(input point_t pt, input logic known, input sph_result_t want);
      if (!steady && $urandom_range(99) < 6) begin
         point_valid <= 1'b0;
         @(posedge clock);
      end
      point_valid <= 1'b1;
      point_beat  <= pt;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      pending_results.push_back(known ? want : spherical_of(pt));
   endtask

   // Stop sending and wait until every outstanding result has come back.
   task automatic drain_results();
      point_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   // Result side back-pressure.
   always @(posedge clock) begin
      if (reset) begin
         result_ready <= 1'b0;
      end else begin
         result_ready <= steady || ($urandom_range(99) >= 6);
      end
   end

   // Result beat check against the oldest expectation.
   always @(posedge clock) begin
      sph_result_t want;
      if (!reset && rsp_bus.valid && result_ready) begin
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result beat radius %0d polar %0d azimuth %0d",
                     $time, rsp_bus.radius, rsp_bus.polar_angle, rsp_bus.azimuth);
            mismatch_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_bus.radius !== want.radius) begin
               $display("%0t: radius expected %0d, got %0d",
                        $time, want.radius, rsp_bus.radius);
               mismatch_count++;
            end
            if (rsp_bus.polar_angle !== want.polar) begin
               $display("%0t: polar_angle expected %0d, got %0d",
                        $time, want.polar, rsp_bus.polar_angle);
               mismatch_count++;
            end
            if (rsp_bus.azimuth !== want.azimuth) begin
               $display("%0t: azimuth expected %0d, got %0d",
                        $time, want.azimuth, rsp_bus.azimuth);
               mismatch_count++;
            end
         end
      end
   end

   // Cycles without any beat accepted on either side.
   always @(posedge clock) begin
      if (reset || (point_valid && req_bus.ready) || (rsp_bus.valid && result_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      while (quiet_cycles < STALL_LIMIT) @(posedge clock);
      $display("cartesian_to_spherical_top regression: fail");
      $finish;
   end

   // Main stimulus: directed table, then random points.
   initial begin
      point_t      pt;
      sph_result_t none;
      none = '0;

      // Points on the z axis and the origin have exact results; the rest are predicted.
      add_row(0, 0, 0, 1'b1, 0, 0, 0);
      add_row(0, 0, 1, 1'b1, 1, 0, 0);
      add_row(0, 0, '1, 1'b1, 1, c2s_pkg::HALF_TURN, 0);
      add_row(0, 0, COORD_MAX, 1'b1, COORD_MAX, 0, 0);
      add_row(0, 0, COORD_MIN, 1'b1, COORD_MIN, c2s_pkg::HALF_TURN, 0);
      add_row(1, 0, 0, 1'b0, 0, 0, 0);
      add_row('1, 0, 0, 1'b0, 0, 0, 0);
      add_row(0, 1, 0, 1'b0, 0, 0, 0);
      add_row(0, '1, 0, 1'b0, 0, 0, 0);
      add_row(COORD_MAX, COORD_MAX, COORD_MAX, 1'b0, 0, 0, 0);
      add_row(COORD_MIN, COORD_MIN, COORD_MIN, 1'b0, 0, 0, 0);
      add_row(COORD_MIN, 0, 0, 1'b0, 0, 0, 0);
      add_row(0, COORD_MIN, 0, 1'b0, 0, 0, 0);
      // Tiny negative y against a large x: the azimuth wraps to zero.
      add_row(COORD_MAX, '1, 0, 1'b0, 0, 0, 0);
      add_row(COORD_MIN, '1, 5, 1'b0, 0, 0, 0);
      add_row(1, 1, 1, 1'b0, 0, 0, 0);
      add_row('1, 1, '1, 1'b0, 0, 0, 0);
      add_row(1, '1, 1, 1'b0, 0, 0, 0);
      add_row('1, '1, '1, 1'b0, 0, 0, 0);
      add_row(COORD_MAX, COORD_MIN, 0, 1'b0, 0, 0, 0);
      add_row(ONE_UNIT, ONE_UNIT, ONE_UNIT, 1'b0, 0, 0, 0);
      add_row(-ONE_UNIT, 0, ONE_UNIT, 1'b0, 0, 0, 0);
      add_row(0, 1, COORD_MIN, 1'b0, 0, 0, 0);
      add_row(COORD_MAX, 0, 1, 1'b0, 0, 0, 0);

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i])
         send_point(directed_rows[i].pt, directed_rows[i].known, directed_rows[i].want);
      drain_results();

      // Random points, with a stretch free of idling and two full drains.
      for (int n = 0; n < RANDOM_PTS; n++) begin
         if (n == 400 || n == 1200) drain_results();
         steady = (n >= 700 && n < 1000);
         pt.x = random_coord();
         pt.y = random_coord();
         pt.z = random_coord();
         send_point(pt, 1'b0, none);
      end
      steady = 1'b0;
      drain_results();
      repeat (DRAIN_WAIT) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("cartesian_to_spherical_top regression: pass");
      end else begin
         $display("cartesian_to_spherical_top regression: fail");
      end
      $finish;
   end

endmodule
